// ----- rtl/jrf_pkg.sv -----
// shared types, codes and defaults for the job ready fifo with delay table
`timescale 1ns / 1ps

package jrf_pkg;

  localparam int READY_DEPTH_DEF = 16;
  localparam int WAIT_SLOTS_DEF  = 16;

  // operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_READY_FULL = 2'd1;
  localparam logic [1:0] ST_WAIT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        job_id;
    logic signed [7:0] delay;
  } req_t;

  typedef struct packed {
    logic [7:0] ready_job_id;
    logic       job_found;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

  typedef struct packed {
    logic append;
    logic rd_en;
    logic wr_en;
    logic commit;
  } wait_cmd_t;

  typedef struct packed {
    logic       load;
    logic       found;
    logic [1:0] status;
  } res_t;

endpackage

// ----- rtl/jrf_ready_fifo.sv -----
// ready fifo: circular job id memory with head, tail and count
`timescale 1ns / 1ps

module jrf_ready_fifo #(
  parameter int READY_DEPTH = jrf_pkg::READY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  jrf_pkg::fifo_cmd_t cmd,
  input  logic [7:0]         push_id,
  output jrf_pkg::fifo_sts_t sts,
  output logic [7:0]         pop_id
);

  localparam int RIW = $clog2(READY_DEPTH);
  localparam int RCW = $clog2(READY_DEPTH + 1);
  localparam logic [RIW-1:0] LAST = RIW'(READY_DEPTH - 1);

  logic [7:0]     mem [READY_DEPTH];
  logic [RIW-1:0] head;
  logic [RIW-1:0] tail;
  logic [RCW-1:0] count;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= push_id;
    end
    if (cmd.pop) begin
      pop_id <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      tail  <= (tail == LAST) ? '0 : tail + 1'b1;
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      head  <= (head == LAST) ? '0 : head + 1'b1;
      count <= count - 1'b1;
    end
  end

  assign sts.full  = (count == RCW'(READY_DEPTH));
  assign sts.empty = (count == '0);

endmodule

// ----- rtl/jrf_wait_table.sv -----
// wait table: job and tick memories kept as a rotating window of slots
`timescale 1ns / 1ps

module jrf_wait_table #(
  parameter int WAIT_SLOTS = jrf_pkg::WAIT_SLOTS_DEF,
  localparam int WIW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1,
  localparam int WCW = $clog2(WAIT_SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  jrf_pkg::wait_cmd_t cmd,
  input  logic [WIW-1:0]     rd_off,
  input  logic [WIW-1:0]     wr_off,
  input  logic [7:0]         wr_job,
  input  logic [6:0]         wr_ticks,
  input  logic [WCW-1:0]     kept,
  output logic [WCW-1:0]     occ,
  output logic [7:0]         rd_job,
  output logic [6:0]         rd_ticks
);

  localparam logic [WIW:0] SLOTS_W = (WIW + 1)'(WAIT_SLOTS);

  logic [7:0]     job_mem   [WAIT_SLOTS];
  logic [6:0]     ticks_mem [WAIT_SLOTS];
  logic [WIW-1:0] base;
  logic [WIW-1:0] rd_slot;
  logic [WIW-1:0] wr_slot;
  logic [WIW-1:0] base_next;
  logic [WCW-1:0] shift;

  // offsets are relative to the oldest entry, wrapped at the slot count
  function automatic logic [WIW-1:0] slot_of(input logic [WIW:0] s);
    logic [WIW:0] r;
    r = (s >= SLOTS_W) ? s - SLOTS_W : s;
    return r[WIW-1:0];
  endfunction

  assign shift     = occ - kept;
  assign base_next = slot_of({1'b0, base} + (WIW + 1)'(shift));
  assign rd_slot   = slot_of({1'b0, base} + {1'b0, rd_off});
  assign wr_slot   = cmd.append ? slot_of({1'b0, base} + (WIW + 1)'(occ))
                                : slot_of({1'b0, base} + {1'b0, wr_off});

  always_ff @(posedge clk) begin
    if (cmd.append || cmd.wr_en) begin
      job_mem[wr_slot]   <= wr_job;
      ticks_mem[wr_slot] <= wr_ticks;
    end
    if (cmd.rd_en) begin
      rd_job   <= job_mem[rd_slot];
      rd_ticks <= ticks_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      occ  <= '0;
    end else if (cmd.commit) begin
      // removed entries drop off the old end, survivors stay in order
      base <= base_next;
      occ  <= kept;
    end else if (cmd.append) begin
      occ <= occ + 1'b1;
    end
  end

endmodule

// ----- rtl/jrf_seq.sv -----
// sequencer: dispatches each request and walks the wait table on a tick
`timescale 1ns / 1ps

module jrf_seq #(
  parameter int WAIT_SLOTS = jrf_pkg::WAIT_SLOTS_DEF,
  localparam int WIW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1,
  localparam int WCW = $clog2(WAIT_SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  jrf_pkg::req_t      req,
  output logic               busy,
  input  jrf_pkg::fifo_sts_t fifo_sts,
  output jrf_pkg::fifo_cmd_t fifo_cmd,
  output logic [7:0]         push_id,
  output jrf_pkg::wait_cmd_t wait_cmd,
  output logic [WIW-1:0]     rd_off,
  output logic [WIW-1:0]     wr_off,
  output logic [7:0]         wr_job,
  output logic [6:0]         wr_ticks,
  output logic [WCW-1:0]     kept_out,
  input  logic [WCW-1:0]     occ,
  input  logic [7:0]         rd_job,
  input  logic [6:0]         rd_ticks,
  input  logic               out_free,
  output jrf_pkg::res_t      res
);

  jrf_pkg::state_t   state;
  jrf_pkg::state_t   state_next;
  logic [1:0]        op;
  logic [7:0]        job;
  logic signed [7:0] delay;
  logic [WIW-1:0]    proc_off;
  logic [WIW-1:0]    proc_off_next;
  logic [WIW-1:0]    wr_pos;
  logic [WIW-1:0]    wr_pos_next;
  logic [WCW-1:0]    kept;
  logic [WCW-1:0]    kept_next;
  logic              found;
  logic              found_next;
  logic [1:0]        status;
  logic [1:0]        status_next;
  logic              keep;
  logic [WIW-1:0]    newest;

  assign busy   = (state != jrf_pkg::S_IDLE);
  assign newest = WIW'(occ - WCW'(1));
  // an expired entry that finds the fifo full stays at zero
  assign keep   = (rd_ticks != '0) || fifo_sts.full;

  always_comb begin
    state_next = state;
    case (state)
      jrf_pkg::S_IDLE: begin
        if (req_valid) state_next = jrf_pkg::S_DISPATCH;
      end
      jrf_pkg::S_DISPATCH: begin
        if (op == jrf_pkg::OP_TICK && occ != '0) state_next = jrf_pkg::S_WALK;
        else state_next = jrf_pkg::S_RESULT;
      end
      jrf_pkg::S_WALK: begin
        if (proc_off == '0) state_next = jrf_pkg::S_RESULT;
      end
      jrf_pkg::S_RESULT: begin
        if (out_free) state_next = jrf_pkg::S_IDLE;
      end
      default: state_next = jrf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    fifo_cmd      = '0;
    wait_cmd      = '0;
    push_id       = job;
    wr_job        = job;
    wr_ticks      = delay[6:0];
    rd_off        = proc_off;
    wr_off        = wr_pos;
    kept_out      = kept;
    res           = '0;
    proc_off_next = proc_off;
    wr_pos_next   = wr_pos;
    kept_next     = kept;
    found_next    = found;
    status_next   = status;
    case (state)
      jrf_pkg::S_IDLE: begin
        found_next  = 1'b0;
        status_next = jrf_pkg::ST_OK;
      end
      jrf_pkg::S_DISPATCH: begin
        case (op)
          jrf_pkg::OP_ADD: begin
            if (delay[7]) begin
              if (fifo_sts.full) status_next = jrf_pkg::ST_READY_FULL;
              else fifo_cmd.push = 1'b1;
            end else if (occ == WCW'(WAIT_SLOTS)) begin
              status_next = jrf_pkg::ST_WAIT_FULL;
            end else begin
              wait_cmd.append = 1'b1;
            end
          end
          jrf_pkg::OP_GET: begin
            if (!fifo_sts.empty) begin
              fifo_cmd.pop = 1'b1;
              found_next   = 1'b1;
            end
          end
          jrf_pkg::OP_TICK: begin
            if (occ != '0) begin
              wait_cmd.rd_en = 1'b1;
              rd_off         = newest;
              proc_off_next  = newest;
              wr_pos_next    = newest;
              kept_next      = '0;
            end
          end
          default: begin
          end
        endcase
      end
      jrf_pkg::S_WALK: begin
        push_id  = rd_job;
        wr_job   = rd_job;
        wr_ticks = (rd_ticks != '0) ? rd_ticks - 1'b1 : '0;
        if (keep) begin
          // survivors pack toward the newest end of the window
          wait_cmd.wr_en = 1'b1;
          wr_pos_next    = wr_pos - 1'b1;
          kept_next      = kept + 1'b1;
          if (rd_ticks == '0) status_next = jrf_pkg::ST_READY_FULL;
        end else begin
          fifo_cmd.push = 1'b1;
        end
        if (proc_off == '0) begin
          wait_cmd.commit = 1'b1;
          kept_out        = kept_next;
        end else begin
          wait_cmd.rd_en = 1'b1;
          rd_off         = proc_off - 1'b1;
          proc_off_next  = proc_off - 1'b1;
        end
      end
      jrf_pkg::S_RESULT: begin
        res.load   = out_free;
        res.found  = found;
        res.status = status;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jrf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == jrf_pkg::S_IDLE && req_valid) begin
      op    <= req.operation;
      job   <= req.job_id;
      delay <= req.delay;
    end
    proc_off <= proc_off_next;
    wr_pos   <= wr_pos_next;
    kept     <= kept_next;
    found    <= found_next;
    status   <= status_next;
  end

endmodule

// ----- rtl/job_ready_fifo_with_delay_table.sv -----
// top level of the job scheduler: ready fifo, wait table and sequencer
`timescale 1ns / 1ps

// Job scheduler with a ready fifo and a table of delayed jobs.
// Request channel (req_valid, req_stall, req) carries an operation: add a job
// (negative delay goes straight to the fifo, otherwise to the wait table),
// get the next ready job, or one timer tick. Every request yields exactly one
// response on (rsp_valid, rsp_stall, rsp): popped job id, found flag, status.
// One request is worked on at a time; req_stall is high while it is busy.
// Add, get and unused codes pass from the dispatch state to the result state,
// which loads the response register; a new request is taken only back in idle.
// A tick walks the wait table between those two states, over N entries (N the wait
// table occupancy, at most WAIT_SLOTS), handling one wait entry per cycle
// through the table's single read port while the next one is read.
// The response sits in an output register, so a new request can be accepted
// while it waits; if rsp_stall holds, the following response waits in its
// final state and the block takes no further request until it moves on.
// Reset (rst, synchronous) empties the fifo and the wait table; memory
// contents are not cleared and there is no clearing pass.
module job_ready_fifo_with_delay_table #(
  parameter int READY_DEPTH = jrf_pkg::READY_DEPTH_DEF,
  parameter int WAIT_SLOTS  = jrf_pkg::WAIT_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  jrf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output jrf_pkg::rsp_t rsp
);

  localparam int WIW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int WCW = $clog2(WAIT_SLOTS + 1);

  jrf_pkg::fifo_cmd_t fifo_cmd;
  jrf_pkg::fifo_sts_t fifo_sts;
  jrf_pkg::wait_cmd_t wait_cmd;
  jrf_pkg::res_t      res;
  logic [7:0]         push_id;
  logic [7:0]         pop_id;
  logic [WIW-1:0]     rd_off;
  logic [WIW-1:0]     wr_off;
  logic [7:0]         wr_job;
  logic [6:0]         wr_ticks;
  logic [WCW-1:0]     kept;
  logic [WCW-1:0]     occ;
  logic [7:0]         rd_job;
  logic [6:0]         rd_ticks;
  logic               busy;
  logic               out_free;

  assign req_stall = busy;
  assign out_free  = !rsp_valid || !rsp_stall;

  jrf_ready_fifo #(
    .READY_DEPTH(READY_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .cmd     (fifo_cmd),
    .push_id (push_id),
    .sts     (fifo_sts),
    .pop_id  (pop_id)
  );

  jrf_wait_table #(
    .WAIT_SLOTS(WAIT_SLOTS)
  ) u_wait (
    .clk      (clk),
    .rst      (rst),
    .cmd      (wait_cmd),
    .rd_off   (rd_off),
    .wr_off   (wr_off),
    .wr_job   (wr_job),
    .wr_ticks (wr_ticks),
    .kept     (kept),
    .occ      (occ),
    .rd_job   (rd_job),
    .rd_ticks (rd_ticks)
  );

  jrf_seq #(
    .WAIT_SLOTS(WAIT_SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .busy      (busy),
    .fifo_sts  (fifo_sts),
    .fifo_cmd  (fifo_cmd),
    .push_id   (push_id),
    .wait_cmd  (wait_cmd),
    .rd_off    (rd_off),
    .wr_off    (wr_off),
    .wr_job    (wr_job),
    .wr_ticks  (wr_ticks),
    .kept_out  (kept),
    .occ       (occ),
    .rd_job    (rd_job),
    .rd_ticks  (rd_ticks),
    .out_free  (out_free),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      rsp.ready_job_id <= res.found ? pop_id : 8'd0;
      rsp.job_found    <= res.found;
      rsp.status       <= res.status;
    end
  end

endmodule

// ----- bench/tb_job_ready_fifo_with_delay_table.sv -----
// testbench for the job scheduler: ready fifo, delay table and timer tick walk
`timescale 1ns / 1ps

module tb_job_ready_fifo_with_delay_table;

  localparam int READY_DEPTH = 16;
  localparam int WAIT_SLOTS = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 3 + WAIT_SLOTS + 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  jrf_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  jrf_pkg::rsp_t rsp;

  job_ready_fifo_with_delay_table #(
    .READY_DEPTH(READY_DEPTH),
    .WAIT_SLOTS (WAIT_SLOTS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state: ready fifo and delay list, oldest entry first
  logic [7:0] ready_jobs[$];
  logic [7:0] waiting_job[$];
  logic [6:0] waiting_ticks[$];
  jrf_pkg::rsp_t expected_rsp[$];

  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_phase_left = 0;
  int stall_run_left = 0;

  function automatic jrf_pkg::rsp_t schedule_step(input jrf_pkg::req_t r);
    jrf_pkg::rsp_t res;
    logic [7:0]    kept_job[$];
    logic [6:0]    kept_ticks[$];
    int            i;
    res = '0;
    case (r.operation)
      jrf_pkg::OP_ADD: begin
        if (r.delay[7]) begin
          if (ready_jobs.size() < READY_DEPTH) ready_jobs.push_back(r.job_id);
          else res.status = jrf_pkg::ST_READY_FULL;
        end else if (waiting_job.size() >= WAIT_SLOTS) begin
          res.status = jrf_pkg::ST_WAIT_FULL;
        end else begin
          waiting_job.push_back(r.job_id);
          waiting_ticks.push_back(r.delay[6:0]);
        end
      end
      jrf_pkg::OP_GET: begin
        if (ready_jobs.size() > 0) begin
          res.ready_job_id = ready_jobs.pop_front();
          res.job_found = 1'b1;
        end
      end
      jrf_pkg::OP_TICK: begin
        // walk newest to oldest; push_front keeps survivors oldest first
        for (i = waiting_job.size() - 1; i >= 0; i--) begin
          if (waiting_ticks[i] != 7'd0) begin
            kept_job.push_front(waiting_job[i]);
            kept_ticks.push_front(waiting_ticks[i] - 7'd1);
          end else if (ready_jobs.size() < READY_DEPTH) begin
            ready_jobs.push_back(waiting_job[i]);
          end else begin
            kept_job.push_front(waiting_job[i]);
            kept_ticks.push_front(7'd0);
            res.status = jrf_pkg::ST_READY_FULL;
          end
        end
        waiting_job = kept_job;
        waiting_ticks = kept_ticks;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // response check first: a response never belongs to the request taken at the same edge
  always @(posedge clk) begin : monitor
    jrf_pkg::rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("response with no request pending", rsp, 0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.ready_job_id !== want.ready_job_id)
            report_mismatch("ready_job_id", rsp.ready_job_id, want.ready_job_id);
          if (rsp.job_found !== want.job_found)
            report_mismatch("job_found", rsp.job_found, want.job_found);
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(schedule_step(req));
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall: phases of no stall, light, heavy and long runs
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_phase_left = $urandom_range(20, 200);
      end
      stall_phase_left--;
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_run_left == 0 && $urandom_range(0, 9) == 0)
            stall_run_left = $urandom_range(5, 20);
          rsp_stall <= (stall_run_left > 0);
          if (stall_run_left > 0) stall_run_left--;
        end
      endcase
    end
  end

  // called at a falling edge; returns at a falling edge with valid low
  task automatic send_item(input logic [1:0] op, input logic [7:0] id,
                           input logic [7:0] dly);
    req_valid = 1'b1;
    req.operation = op;
    req.job_id = id;
    req.delay = dly;
    do @(posedge clk); while (req_stall);
    items_sent++;
    @(negedge clk);
    req_valid = 1'b0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic wait_drained();
    while (expected_rsp.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] ready_delay();
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic test_empty_and_unused();
    send_item(jrf_pkg::OP_GET, 8'h00, 8'h00);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
    send_item(OP_UNUSED, 8'h00, 8'h00);
  endtask

  task automatic test_ready_extremes();
    send_item(jrf_pkg::OP_ADD, 8'hFF, 8'h80);
    send_item(jrf_pkg::OP_ADD, 8'h00, 8'hFF);
    send_item(jrf_pkg::OP_GET, 8'h00, 8'h00);
    send_item(jrf_pkg::OP_GET, 8'h00, 8'h00);
    send_item(jrf_pkg::OP_GET, 8'hFF, 8'hFF);
  endtask

  task automatic test_delay_extremes();
    send_item(jrf_pkg::OP_ADD, 8'h5A, 8'h00);
    send_item(jrf_pkg::OP_ADD, 8'hA5, 8'h7F);
    send_item(jrf_pkg::OP_ADD, 8'h3C, 8'h01);
    send_item(jrf_pkg::OP_TICK, 8'h00, 8'h00);
    send_item(jrf_pkg::OP_TICK, 8'hFF, 8'hFF);
    send_item(jrf_pkg::OP_GET, 8'h00, 8'h00);
    send_item(jrf_pkg::OP_GET, 8'h00, 8'h00);
    send_item(jrf_pkg::OP_GET, 8'h00, 8'h00);
  endtask

  task automatic test_fifo_overflow();
    repeat (READY_DEPTH + 2) send_item(jrf_pkg::OP_ADD, 8'($urandom), ready_delay());
    repeat ($urandom_range(4, READY_DEPTH + 2))
      send_item(jrf_pkg::OP_GET, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_wait_overflow();
    repeat (WAIT_SLOTS + 2)
      send_item(jrf_pkg::OP_ADD, 8'($urandom), 8'($urandom_range(0, 3)));
    // tick the table empty, popping whenever the fifo blocks expiry
    while (waiting_job.size() != 0) begin
      if (ready_jobs.size() == READY_DEPTH)
        send_item(jrf_pkg::OP_GET, 8'($urandom), 8'($urandom));
      else
        send_item(jrf_pkg::OP_TICK, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_tick_retry();
    while (ready_jobs.size() < READY_DEPTH)
      send_item(jrf_pkg::OP_ADD, 8'($urandom), ready_delay());
    repeat ($urandom_range(1, 3)) send_item(jrf_pkg::OP_ADD, 8'($urandom), 8'h00);
    send_item(jrf_pkg::OP_TICK, 8'($urandom), 8'($urandom));
    send_item(jrf_pkg::OP_TICK, 8'($urandom), 8'($urandom));
    send_item(jrf_pkg::OP_GET, 8'($urandom), 8'($urandom));
    send_item(jrf_pkg::OP_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_random_mix(input int count);
    int stop_at;
    int kind;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind <= 4) begin
        repeat ($urandom_range(1, 8))
          send_item(jrf_pkg::OP_ADD, 8'($urandom), ready_delay());
      end else if (kind <= 8) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0)
            send_item(jrf_pkg::OP_ADD, 8'($urandom), 8'($urandom_range(0, 127)));
          else
            send_item(jrf_pkg::OP_ADD, 8'($urandom), 8'($urandom_range(0, 6)));
        end
      end else if (kind <= 11) begin
        repeat ($urandom_range(1, 4))
          send_item(jrf_pkg::OP_TICK, 8'($urandom), 8'($urandom));
      end else if (kind <= 15) begin
        repeat ($urandom_range(1, 8))
          send_item(jrf_pkg::OP_GET, 8'($urandom), 8'($urandom));
      end else if (kind == 16) begin
        repeat ($urandom_range(1, 3))
          send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end else if (kind == 17) begin
        test_fifo_overflow();
      end else if (kind == 18) begin
        test_wait_overflow();
      end else begin
        test_tick_retry();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_and_unused();
    test_ready_extremes();
    test_delay_extremes();
    test_fifo_overflow();
    test_wait_overflow();
    // hold the next requests until all responses are back
    wait_drained();
    test_tick_retry();
    test_random_mix(RANDOM_ITEMS);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_rsp.size() != 0) report_mismatch("responses missing", 0, expected_rsp.size());
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
